// File: hdl/stqp_pkg.sv
// shared constants for the segment tree query planner
package stqp_pkg;

	localparam int FANOUT_POWER_DEF = 4;
	localparam int LEAF_BITS_DEF    = 20;
	localparam int MAX_LEVELS_DEF   = 5;

	// width of the tree_level result field
	localparam int TREE_LEVEL_W = 3;

endpackage

// File: hdl/segment_tree_query_planner_unit.sv
// Segment tree range query planner: level table set-up and per-query range walk.
// An accepted request enters S_LEVEL, which puts its ranges into the output register as the
// walk climbs the tree, with an S_TAIL step after a head range; s_tready stays low until the
// last range sits in the output register, so no new request is taken before then.
// A leaf count write rebuilds the level table, one S_CFG_DIV and S_CFG_BASE step per level.
// Reset: arst_n clears the leaf count, the level table and all handshake state.
module segment_tree_query_planner_unit import stqp_pkg::*; #(
	parameter int FANOUT_POWER = FANOUT_POWER_DEF,
	parameter int LEAF_BITS    = LEAF_BITS_DEF,
	parameter int MAX_LEVELS   = MAX_LEVELS_DEF,
	localparam int W           = LEAF_BITS + 1,
	localparam int IN_W        = ((2 * W + 7) / 8) * 8,
	localparam int OUT_RAW_W   = TREE_LEVEL_W + 2 * W + LEAF_BITS,
	localparam int OUT_W       = ((OUT_RAW_W + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [W-1:0]     cfg_wdata,  // leaf_count
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,    // query_begin, query_end
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,    // tree_level, span_begin, span_end, level_base
	output logic             m_tlast,    // is_last
	output logic             m_tuser     // bad_query
);

	localparam int LVL_W = $clog2(MAX_LEVELS + 1);
	localparam int IDX_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
	localparam logic [W-1:0] FAN_M1 = W'((1 << FANOUT_POWER) - 1);
	localparam logic [W-1:0] ONE    = W'(1);
	localparam logic [LVL_W-1:0] MAX_LVL = LVL_W'(MAX_LEVELS);

	typedef enum logic [4:0] {
		S_IDLE     = 5'b00001,
		S_CFG_DIV  = 5'b00010,
		S_CFG_BASE = 5'b00100,
		S_LEVEL    = 5'b01000,
		S_TAIL     = 5'b10000
	} state_t;

	state_t state_q;

	logic [W-1:0]         leaf_count_q;
	logic [W-1:0]         n_q;
	logic [W-1:0]         base_acc_q;
	logic [LVL_W-1:0]     level_total_q;
	logic [LEAF_BITS-1:0] level_bases_q [MAX_LEVELS];

	logic [W-1:0]     b_q, e_q;
	logic [LVL_W-1:0] lvl_q;
	logic             bad_q;

	logic                 out_valid_q;
	logic [LVL_W-1:0]     out_lvl_q;
	logic [W-1:0]         out_begin_q, out_end_q;
	logic [LEAF_BITS-1:0] out_base_q;
	logic                 out_last_q, out_bad_q;

	// shared adder
	logic [W-1:0] add_a, add_b, sum;

	logic [W-1:0]         in_begin, in_end, cfg_clamped;
	logic [W-1:0]         pb, pe, ge, head_end;
	logic [LVL_W-1:0]     lvl_m1;
	logic [LEAF_BITS-1:0] cur_base;
	logic                 head, tail, stop, out_free, out_load, cfg_load;

	assign in_begin = s_tdata[W-1:0];
	assign in_end   = s_tdata[2*W-1:W];

	// leaf counts above the tree capacity saturate
	assign cfg_clamped = (cfg_wdata[W-1] && (|cfg_wdata[W-2:0])) ? {1'b1, {(W-1){1'b0}}}
		: cfg_wdata;

	assign pb       = {{FANOUT_POWER{1'b0}}, b_q[W-1:FANOUT_POWER]};
	assign pe       = {{FANOUT_POWER{1'b0}}, e_q[W-1:FANOUT_POWER]};
	assign ge       = {e_q[W-1:FANOUT_POWER], {FANOUT_POWER{1'b0}}};
	assign head_end = {sum[W-1-FANOUT_POWER:0], {FANOUT_POWER{1'b0}}};
	assign head     = |b_q[FANOUT_POWER-1:0];
	assign tail     = |e_q[FANOUT_POWER-1:0];
	assign stop     = (pb == pe) || (lvl_q >= level_total_q);
	assign lvl_m1   = lvl_q - LVL_W'(1);
	assign cur_base = (lvl_q == '0) ? '0 : level_bases_q[lvl_m1[IDX_W-1:0]];
	assign out_free = !out_valid_q || m_tready;

	// a leaf count write restarts the table build whenever no request is being walked
	assign cfg_load = cfg_we && (state_q != S_LEVEL) && (state_q != S_TAIL);

	// the walk puts a range into the output register this cycle
	assign out_load = out_free && (((state_q == S_LEVEL) && (bad_q || stop || head || tail))
		|| ((state_q == S_TAIL) && tail));

	always_comb begin
		unique case (state_q)
			S_CFG_DIV: begin
				add_a = n_q;
				add_b = FAN_M1;
			end
			S_CFG_BASE: begin
				add_a = base_acc_q;
				add_b = n_q;
			end
			default: begin
				add_a = pb;
				add_b = ONE;
			end
		endcase
	end

	assign sum = add_a + add_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			leaf_count_q  <= '0;
			n_q           <= '0;
			base_acc_q    <= '0;
			level_total_q <= '0;
			for (int i = 0; i < MAX_LEVELS; i++) begin
				level_bases_q[i] <= '0;
			end
			b_q         <= '0;
			e_q         <= '0;
			lvl_q       <= '0;
			bad_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_lvl_q   <= '0;
			out_begin_q <= '0;
			out_end_q   <= '0;
			out_base_q  <= '0;
			out_last_q  <= 1'b0;
			out_bad_q   <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_load) begin
				leaf_count_q  <= cfg_clamped;
				n_q           <= cfg_clamped;
				base_acc_q    <= '0;
				level_total_q <= '0;
				for (int i = 0; i < MAX_LEVELS; i++) begin
					level_bases_q[i] <= '0;
				end
				state_q <= S_CFG_DIV;
			end else begin
				unique case (state_q)
					S_IDLE: begin
						if (s_tvalid) begin
							b_q     <= in_begin;
							e_q     <= in_end;
							lvl_q   <= '0;
							bad_q   <= (in_begin > in_end) || (in_end > leaf_count_q);
							state_q <= S_LEVEL;
						end
					end
					S_CFG_DIV: begin
						if ((n_q > ONE) && (level_total_q < MAX_LVL)) begin
							n_q     <= {{FANOUT_POWER{1'b0}}, sum[W-1:FANOUT_POWER]};
							state_q <= S_CFG_BASE;
						end else begin
							state_q <= S_IDLE;
						end
					end
					S_CFG_BASE: begin
						level_bases_q[level_total_q[IDX_W-1:0]] <= base_acc_q[LEAF_BITS-1:0];
						base_acc_q    <= sum;
						level_total_q <= level_total_q + LVL_W'(1);
						state_q       <= S_CFG_DIV;
					end
					S_LEVEL: begin
						priority if (bad_q) begin
							if (out_free) begin
								out_lvl_q   <= '0;
								out_begin_q <= '0;
								out_end_q   <= '0;
								out_base_q  <= '0;
								out_last_q  <= 1'b1;
								out_bad_q   <= 1'b1;
								state_q     <= S_IDLE;
							end
						end else if (stop) begin
							if (out_free) begin
								out_lvl_q   <= lvl_q;
								out_begin_q <= b_q;
								out_end_q   <= e_q;
								out_base_q  <= cur_base;
								out_last_q  <= 1'b1;
								out_bad_q   <= 1'b0;
								state_q     <= S_IDLE;
							end
						end else if (head) begin
							if (out_free) begin
								out_lvl_q   <= lvl_q;
								out_begin_q <= b_q;
								out_end_q   <= head_end;
								out_base_q  <= cur_base;
								out_last_q  <= 1'b0;
								out_bad_q   <= 1'b0;
								state_q     <= S_TAIL;
							end
						end else if (tail) begin
							if (out_free) begin
								out_lvl_q   <= lvl_q;
								out_begin_q <= ge;
								out_end_q   <= e_q;
								out_base_q  <= cur_base;
								out_last_q  <= 1'b0;
								out_bad_q   <= 1'b0;
								b_q         <= pb;
								e_q         <= pe;
								lvl_q       <= lvl_q + LVL_W'(1);
							end
						end else begin
							// range sits on group edges, climb without a result
							b_q   <= pb;
							e_q   <= pe;
							lvl_q <= lvl_q + LVL_W'(1);
						end
					end
					S_TAIL: begin
						// head already sent, so the parent range starts one group later
						if (!tail || out_free) begin
							if (tail) begin
								out_lvl_q   <= lvl_q;
								out_begin_q <= ge;
								out_end_q   <= e_q;
								out_base_q  <= cur_base;
								out_last_q  <= 1'b0;
								out_bad_q   <= 1'b0;
							end
							b_q     <= sum;
							e_q     <= pe;
							lvl_q   <= lvl_q + LVL_W'(1);
							state_q <= S_LEVEL;
						end
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
			end
		end
	end

	assign s_tready = (state_q == S_IDLE) && !cfg_we;
	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_bad_q;
	assign m_tdata  = {{(OUT_W - OUT_RAW_W){1'b0}}, out_base_q, out_end_q, out_begin_q,
		TREE_LEVEL_W'(out_lvl_q)};

	// a flagged request gives a single range, which closes the request
	a_bad_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("bad request result not marked last");

	a_level_total_range: assert property (@(posedge clk) disable iff (!arst_n)
		level_total_q <= MAX_LVL)
		else $error("level count above maximum");

	a_out_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> out_lvl_q <= level_total_q)
		else $error("range emitted above the top level");

	a_tail_after_head: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_TAIL |-> head && !bad_q)
		else $error("tail step entered without a head range");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready && state_q == S_LEVEL)
		else $error("request accepted while the walk did not start");

endmodule
